// ===== rtl/core/spd_pkg.sv =====
package spd_pkg;

   // defaults for the top level parameters and the start code register
   localparam int          MAX_PAYLOAD_DEFAULT = 256;
   localparam logic [15:0] START_CODE_RESET    = 16'hEF01;

   // header geometry
   localparam int ADDR_BYTES    = 4;
   localparam int LENGTH_EXTRA  = 2;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // frame parsing phases
   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ADDR,
      PH_TYPE,
      PH_LENH,
      PH_LENL,
      PH_PAY,
      PH_CKH,
      PH_CKL
   } phase_type;

   // one result beat
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [31:0] packet_address;
      logic [7:0]  packet_type;
      logic [8:0]  payload_length;
      logic [15:0] checksum_received;
      logic        checksum_ok;
      logic        last;
   } result_type;

endpackage

// ===== rtl/core/spd_parser.sv =====
module spd_parser #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         byte_in,
   input  logic [15:0]        start_code,
   output logic               has_result,
   output spd_pkg::result_type result
);

   localparam int             PayCountWidth = $clog2(MAX_PAYLOAD + 1);
   localparam int             CountWidth    = (PayCountWidth > 3) ? PayCountWidth : 3;
   localparam logic [15:0]    LengthMax     = 16'(MAX_PAYLOAD + spd_pkg::LENGTH_EXTRA);
   localparam logic [15:0]    LengthMin     = 16'(spd_pkg::LENGTH_EXTRA);
   localparam logic [CountWidth-1:0] AddrLast = CountWidth'(spd_pkg::ADDR_BYTES - 1);

   spd_pkg::phase_type     phase_ff, phase_in;
   logic                   prev_valid_ff, prev_valid_in;
   logic [7:0]             prev_byte_ff, prev_byte_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [31:0]            address_ff, address_in;
   logic [7:0]             type_ff, type_in;
   logic [15:0]            length_ff, length_in;
   logic [15:0]            sum_ff, sum_in;
   logic [7:0]             ck_high_ff, ck_high_in;

   logic                   start_match;
   logic [15:0]            length_full;
   logic                   length_bad;
   logic [15:0]            pay_len;
   logic [15:0]            count_wide;
   logic                   pay_done;
   logic [15:0]            ck_full;
   logic [15:0]            sum_next_pay;

   // shared decode
   always_comb begin
      start_match  = prev_valid_ff && (prev_byte_ff == start_code[15:8])
                     && (byte_in == start_code[7:0]);
      length_full  = {length_ff[15:8], byte_in};
      length_bad   = (length_full < LengthMin) || (length_full > LengthMax);
      pay_len      = length_ff - LengthMin;
      count_wide   = 16'(count_ff);
      pay_done     = (count_wide + 16'd1) >= pay_len;
      ck_full      = {ck_high_ff, byte_in};
      sum_next_pay = sum_ff + 16'(byte_in);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            spd_pkg::PH_HUNT: begin
               if (start_match) phase_in = spd_pkg::PH_ADDR;
            end
            spd_pkg::PH_ADDR: begin
               if (count_ff == AddrLast) phase_in = spd_pkg::PH_TYPE;
            end
            spd_pkg::PH_TYPE: phase_in = spd_pkg::PH_LENH;
            spd_pkg::PH_LENH: phase_in = spd_pkg::PH_LENL;
            spd_pkg::PH_LENL: begin
               if (length_bad) phase_in = spd_pkg::PH_HUNT;
               else if (length_full == LengthMin) phase_in = spd_pkg::PH_CKH;
               else phase_in = spd_pkg::PH_PAY;
            end
            spd_pkg::PH_PAY: begin
               if (pay_done) phase_in = spd_pkg::PH_CKH;
            end
            spd_pkg::PH_CKH: phase_in = spd_pkg::PH_CKL;
            spd_pkg::PH_CKL: phase_in = spd_pkg::PH_HUNT;
            default: phase_in = spd_pkg::PH_HUNT;
         endcase
      end
   end

   // header, counter, sum and result
   always_comb begin
      prev_valid_in = prev_valid_ff;
      prev_byte_in  = prev_byte_ff;
      count_in      = count_ff;
      address_in    = address_ff;
      type_in       = type_ff;
      length_in     = length_ff;
      sum_in        = sum_ff;
      ck_high_in    = ck_high_ff;
      has_result    = 1'b0;

      result                   = '0;
      result.packet_address    = address_ff;
      result.packet_type       = type_ff;

      if (step) begin
         case (phase_ff)
            spd_pkg::PH_HUNT: begin
               if (start_match) begin
                  prev_valid_in = 1'b0;
                  prev_byte_in  = 8'd0;
                  count_in      = '0;
               end else begin
                  prev_valid_in = 1'b1;
                  prev_byte_in  = byte_in;
               end
            end
            spd_pkg::PH_ADDR: begin
               address_in = {address_ff[23:0], byte_in};
               count_in   = (count_ff == AddrLast) ? '0 : count_ff + 1'b1;
            end
            spd_pkg::PH_TYPE: type_in = byte_in;
            spd_pkg::PH_LENH: length_in = {byte_in, 8'd0};
            spd_pkg::PH_LENL: begin
               length_in = length_full;
               count_in  = '0;
               sum_in    = 16'(length_ff[15:8]) + 16'(byte_in) + 16'(type_ff);
               if (length_bad) begin
                  has_result    = 1'b1;
                  result.kind   = spd_pkg::KIND_ERROR;
                  result.last   = 1'b1;
                  prev_valid_in = 1'b0;
                  prev_byte_in  = 8'd0;
               end
            end
            spd_pkg::PH_PAY: begin
               sum_in                = sum_next_pay;
               count_in              = pay_done ? '0 : count_ff + 1'b1;
               has_result            = 1'b1;
               result.kind           = spd_pkg::KIND_PAYLOAD;
               result.data_byte      = byte_in;
               result.byte_index     = count_wide[7:0];
               result.payload_length = pay_len[8:0];
            end
            spd_pkg::PH_CKH: ck_high_in = byte_in;
            spd_pkg::PH_CKL: begin
               has_result               = 1'b1;
               result.kind              = spd_pkg::KIND_END;
               result.payload_length    = pay_len[8:0];
               result.checksum_received = ck_full;
               result.checksum_ok       = (ck_full == sum_ff);
               result.last              = 1'b1;
               prev_valid_in            = 1'b0;
               prev_byte_in             = 8'd0;
               count_in                 = '0;
            end
            default: begin
               prev_valid_in = 1'b0;
               count_in      = '0;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= spd_pkg::PH_HUNT;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         prev_valid_ff <= prev_valid_in;
         count_ff      <= count_in;
      end
   end

   // header and sum holding
   always_ff @(posedge clock) begin
      prev_byte_ff <= prev_byte_in;
      address_ff   <= address_in;
      type_ff      <= type_in;
      length_ff    <= length_in;
      sum_ff       <= sum_in;
      ck_high_ff   <= ck_high_in;
   end

endmodule

// ===== rtl/core/serial_packet_deframer.sv =====
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_byte_in
// rsp      out        rsp_valid / rsp_ready  rsp_kind .. rsp_last
// csr      in         csr_valid / csr_ready  csr_start_code
//
// one byte per cycle sustained while rsp_ready is high; a result is offered
// on the rsp ports once its byte has been taken into the input register, the
// parser step has run and the result register has loaded. reset clears the
// phase to hunting and the start code to its default. a stalled result holds
// the result register and the input register keeps one more byte; csr_ready
// is always high.
module serial_packet_deframer #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [31:0] rsp_packet_address,
   output logic [7:0]  rsp_packet_type,
   output logic [8:0]  rsp_payload_length,
   output logic [15:0] rsp_checksum_received,
   output logic        rsp_checksum_ok,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_start_code
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                out_valid_ff, out_valid_in;
   spd_pkg::result_type out_ff, out_in;
   logic [15:0]         start_code_ff, start_code_in;

   logic                advance;
   logic                step;
   logic                has_result;
   spd_pkg::result_type result;

   // handshake
   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // input beat register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // start code register
   assign start_code_in = (csr_valid && csr_ready) ? csr_start_code : start_code_ff;

   spd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_in    (in_byte_ff),
      .start_code (start_code_ff),
      .has_result (has_result),
      .result     (result)
   );

   // result beat register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = step && has_result;
         if (step && has_result) out_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         start_code_ff <= spd_pkg::START_CODE_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         start_code_ff <= start_code_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   // result ports
   assign rsp_valid             = out_valid_ff;
   assign rsp_kind              = out_ff.kind;
   assign rsp_data_byte         = out_ff.data_byte;
   assign rsp_byte_index        = out_ff.byte_index;
   assign rsp_packet_address    = out_ff.packet_address;
   assign rsp_packet_type       = out_ff.packet_type;
   assign rsp_payload_length    = out_ff.payload_length;
   assign rsp_checksum_received = out_ff.checksum_received;
   assign rsp_checksum_ok       = out_ff.checksum_ok;
   assign rsp_last              = out_ff.last;

endmodule
